[rtl/g711_law_codec_top_defines.svh]
`ifndef G711_LAW_CODEC_TOP_DEFINES_SVH
`define G711_LAW_CODEC_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define G711_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequent follows the request by the result latency.
`define G711_ASSERT_LAT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##2 (cons)) \
      else $error(msg);

`endif

[rtl/g711_pkg.sv]
package g711_pkg;

   typedef enum logic {
      OP_ENCODE = 1'b0,
      OP_DECODE = 1'b1
   } op_type;

   typedef enum logic {
      LAW_MU = 1'b0,
      LAW_A  = 1'b1
   } law_type;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register index, taken from paddr above the byte offset
   localparam logic CSR_LAW_SELECT = 1'b0;

   localparam logic [12:0] MU_CLAMP = 13'h1FFF;
   localparam logic [16:0] MU_BIAS  = 17'd33;
   localparam logic [11:0] A_CLAMP  = 12'hFFF;
   localparam logic [7:0]  A_XOR    = 8'h55;

   typedef struct packed {
      logic        valid;
      op_type      op;
      law_type     law;
      logic [15:0] sample;
      logic [7:0]  code;
   } stage_type;

endpackage

[rtl/g711_law_codec_top.sv]
// G.711 mu-law / A-law companding codec. A request is taken whenever start is high;
// busy never rises, so one request is accepted every cycle and its result appears on
// rsp_strobe once it has passed the input register and then the result register (with the
// leading-one priority encoder and shifts between them). The receiver cannot stall:
// each result is shown for one cycle only. law_select (byte address 0) chooses mu-law
// (0) or A-law with byte swapping (1) and is sampled when the request is accepted.
module g711_law_codec_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_op,
   input  logic signed [15:0]               req_sample_in,
   input  logic [7:0]                       req_code_in,
   output logic                             rsp_strobe,
   output logic [7:0]                       rsp_code_out,
   output logic signed [15:0]               rsp_sample_out,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [g711_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [g711_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [g711_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready
);

   g711_pkg::law_type   law_ff;
   g711_pkg::stage_type stage_ff;
   g711_pkg::stage_type stage_in;
   logic                strobe_ff;
   logic [7:0]          code_ff;
   logic [7:0]          code_in;
   logic [15:0]         sample_ff;
   logic [15:0]         sample_in;
   logic                csr_write;

   logic        mu_neg;
   logic [16:0] mu_abs;
   logic [16:0] mu_biased;
   logic [12:0] mu_mag;
   logic [2:0]  mu_seg;
   logic [12:0] mu_shifted;
   logic [7:0]  mu_enc;

   logic [15:0] a_swapped;
   logic        a_neg;
   logic [16:0] a_abs;
   logic [11:0] a_mag;
   logic [2:0]  a_seg;
   logic [2:0]  a_shift;
   logic [11:0] a_shifted;
   logic [7:0]  a_enc;

   logic [7:0]  mu_n;
   logic [12:0] mu_lin;
   logic [15:0] mu_dec;
   logic [7:0]  a_n;
   logic [11:0] a_lin;
   logic [15:0] a_signed;
   logic [15:0] a_dec;

   assign busy      = 1'b0;
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == g711_pkg::CSR_LAW_SELECT)
                    ? {{(g711_pkg::CSR_DATA_W-1){1'b0}}, law_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         law_ff <= g711_pkg::LAW_MU;
      end else if (csr_write && paddr[2] == g711_pkg::CSR_LAW_SELECT) begin
         law_ff <= g711_pkg::law_type'(pwdata[0]);
      end
   end

   always_comb begin
      stage_in.valid  = start && !busy;
      stage_in.op     = g711_pkg::op_type'(req_op);
      stage_in.law    = law_ff;
      stage_in.sample = req_sample_in;
      stage_in.code   = req_code_in;
   end

   // encode paths
   always_comb begin
      mu_neg    = stage_ff.sample[15];
      mu_abs    = mu_neg ? 17'(17'h10000 - {1'b0, stage_ff.sample}) : {1'b0, stage_ff.sample};
      mu_biased = mu_abs + g711_pkg::MU_BIAS;
      mu_mag    = (mu_biased > {4'b0, g711_pkg::MU_CLAMP}) ? g711_pkg::MU_CLAMP
                                                          : mu_biased[12:0];
      mu_seg = 3'd0;
      for (int i = 1; i < 8; i++) begin
         if (mu_mag[5+i]) begin
            mu_seg = 3'(i);
         end
      end
      mu_shifted = mu_mag >> ({1'b0, mu_seg} + 4'd1);
      mu_enc     = ~{mu_neg, mu_seg, mu_shifted[3:0]};

      a_swapped = {stage_ff.sample[7:0], stage_ff.sample[15:8]};
      a_neg     = a_swapped[15];
      a_abs     = a_neg ? 17'(17'h10000 - {1'b0, a_swapped}) : {1'b0, a_swapped};
      a_mag     = (a_abs > {5'b0, g711_pkg::A_CLAMP}) ? g711_pkg::A_CLAMP : a_abs[11:0];
      a_seg = 3'd0;
      for (int i = 1; i < 8; i++) begin
         if (a_mag[4+i]) begin
            a_seg = 3'(i);
         end
      end
      a_shift   = (a_seg == 3'd0) ? 3'd1 : a_seg;
      a_shifted = a_mag >> a_shift;
      a_enc     = {a_neg, a_seg, a_shifted[3:0]} ^ g711_pkg::A_XOR;
   end

   // decode paths
   always_comb begin
      mu_n   = ~stage_ff.code;
      mu_lin = 13'({7'b0, 1'b1, mu_n[3:0], 1'b1} << mu_n[6:4]) - 13'd33;
      mu_dec = mu_n[7] ? 16'(16'd0 - {3'b0, mu_lin}) : {3'b0, mu_lin};

      a_n = stage_ff.code ^ g711_pkg::A_XOR;
      if (a_n[6:4] != 3'd0) begin
         a_lin = 12'({6'b0, 1'b1, a_n[3:0], 1'b1} << (a_n[6:4] - 3'd1));
      end else begin
         a_lin = {7'b0, a_n[3:0], 1'b1};
      end
      a_signed = a_n[7] ? 16'(16'd0 - {4'b0, a_lin}) : {4'b0, a_lin};
      a_dec    = {a_signed[7:0], a_signed[15:8]};
   end

   always_comb begin
      code_in   = 8'd0;
      sample_in = 16'd0;
      unique case (stage_ff.op)
         g711_pkg::OP_ENCODE: begin
            code_in = (stage_ff.law == g711_pkg::LAW_A) ? a_enc : mu_enc;
         end
         g711_pkg::OP_DECODE: begin
            sample_in = (stage_ff.law == g711_pkg::LAW_A) ? a_dec : mu_dec;
         end
         default: begin
            code_in = 8'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff  <= '0;
         strobe_ff <= 1'b0;
         code_ff   <= 8'd0;
         sample_ff <= 16'd0;
      end else begin
         stage_ff  <= stage_in;
         strobe_ff <= stage_ff.valid;
         code_ff   <= code_in;
         sample_ff <= sample_in;
      end
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_code_out   = code_ff;
   assign rsp_sample_out = sample_ff;

endmodule

[rtl/g711_chk.sv]
`include "g711_law_codec_top_defines.svh"

module g711_chk (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic                             req_op,
   input logic                             rsp_strobe,
   input logic [7:0]                       rsp_code_out,
   input logic [15:0]                      rsp_sample_out,
   input logic                             pready
);

   logic accept;
   logic accept_decode;
   logic decode_clean;
   logic one_field_zero;

   assign accept         = start && !busy;
   assign accept_decode  = accept && req_op == g711_pkg::OP_DECODE;
   assign decode_clean   = rsp_strobe && rsp_code_out == 8'd0;
   assign one_field_zero = rsp_code_out == 8'd0 || rsp_sample_out == 16'd0;

   `G711_ASSERT_LAT(a_result_follows, accept, rsp_strobe, "request produced no result")
   `G711_ASSERT_LAT(a_no_phantom, !accept, !rsp_strobe, "result without a request")
   `G711_ASSERT_LAT(a_decode_code_zero, accept_decode, decode_clean, "decode result has a code")
   `G711_ASSERT_NOW(a_one_field, rsp_strobe, one_field_zero, "both result fields nonzero")
   `G711_ASSERT_NOW(a_never_busy, 1'b1, !busy && pready, "codec stalled a port")

endmodule

bind g711_law_codec_top g711_chk u_g711_chk (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_op         (req_op),
   .rsp_strobe     (rsp_strobe),
   .rsp_code_out   (rsp_code_out),
   .rsp_sample_out (rsp_sample_out),
   .pready         (pready)
);

[tb/g711_law_codec_top_test.sv]
module g711_law_codec_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [7:0]  code;
      logic [15:0] sample;
   } conversion_type;

   localparam logic [g711_pkg::CSR_ADDR_W-1:0] LAW_SELECT_ADDR =
      {g711_pkg::CSR_LAW_SELECT, 2'b00};

   logic                            clock;
   logic                            reset;
   logic                            start;
   logic                            busy;
   logic                            req_op;
   logic signed [15:0]              req_sample_in;
   logic [7:0]                      req_code_in;
   logic                            rsp_strobe;
   logic [7:0]                      rsp_code_out;
   logic signed [15:0]              rsp_sample_out;
   logic                            psel;
   logic                            penable;
   logic                            pwrite;
   logic [g711_pkg::CSR_ADDR_W-1:0] paddr;
   logic [g711_pkg::CSR_DATA_W-1:0] pwdata;
   logic [g711_pkg::CSR_DATA_W-1:0] prdata;
   logic                            pready;

   g711_pkg::law_type active_law;
   conversion_type    pending_conversions[$];
   int                error_count;

   g711_law_codec_top u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_sample_in  (req_sample_in),
      .req_code_in    (req_code_in),
      .rsp_strobe     (rsp_strobe),
      .rsp_code_out   (rsp_code_out),
      .rsp_sample_out (rsp_sample_out),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic logic [15:0] swap_halves(logic [15:0] v);
      return {v[7:0], v[15:8]};
   endfunction

   function automatic logic [16:0] magnitude_of(logic [15:0] v, output logic neg);
      neg = v[15];
      return neg ? 17'h10000 - {1'b0, v} : {1'b0, v};
   endfunction

   function automatic logic [7:0] mu_compress(logic [15:0] s);
      logic        neg;
      logic [17:0] mag;
      int          pos;
      logic [3:0]  mant;
      logic [7:0]  c;
      mag = {1'b0, magnitude_of(s, neg)} + {1'b0, g711_pkg::MU_BIAS};
      if (mag > {5'b0, g711_pkg::MU_CLAMP}) mag = {5'b0, g711_pkg::MU_CLAMP};
      pos = 12;
      while (pos >= 5 && !mag[pos]) pos--;
      if (pos < 5) pos = 5;
      mant = 4'(mag >> (pos - 4));
      c = {neg, 3'(pos - 5), mant};
      return ~c;
   endfunction

   function automatic logic [15:0] mu_expand(logic [7:0] c);
      logic [7:0]  n;
      int          pos;
      int unsigned val;
      n = ~c;
      pos = int'(n[6:4]) + 5;
      val = ((32'd1 << pos) | (32'(n[3:0]) << (pos - 4)) | (32'd1 << (pos - 5)))
            - 32'(g711_pkg::MU_BIAS);
      if (n[7]) val = 32'h10000 - val;
      return val[15:0];
   endfunction

   function automatic logic [7:0] a_compress(logic [15:0] s);
      logic        neg;
      logic [16:0] mag;
      int          pos;
      logic [3:0]  mant;
      mag = magnitude_of(swap_halves(s), neg);
      if (mag > {5'b0, g711_pkg::A_CLAMP}) mag = {5'b0, g711_pkg::A_CLAMP};
      pos = 11;
      while (pos >= 5 && !mag[pos]) pos--;
      mant = 4'(mag >> ((pos == 4) ? 1 : pos - 4));
      return {neg, 3'(pos - 4), mant} ^ g711_pkg::A_XOR;
   endfunction

   function automatic logic [15:0] a_expand(logic [7:0] c);
      logic [7:0]  n;
      int          pos;
      int unsigned val;
      n = c ^ g711_pkg::A_XOR;
      pos = int'(n[6:4]) + 4;
      if (pos != 4)
         val = (32'd1 << pos) | (32'(n[3:0]) << (pos - 4)) | (32'd1 << (pos - 5));
      else
         val = (32'(n[3:0]) << 1) | 32'd1;
      if (n[7]) val = 32'h10000 - val;
      return swap_halves(val[15:0]);
   endfunction

   function automatic conversion_type convert_request(g711_pkg::op_type op,
                                                      logic [15:0] sample,
                                                      logic [7:0] code,
                                                      g711_pkg::law_type law);
      conversion_type r;
      r.code = 8'h00;
      r.sample = 16'h0000;
      if (op == g711_pkg::OP_ENCODE)
         r.code = (law == g711_pkg::LAW_A) ? a_compress(sample) : mu_compress(sample);
      else
         r.sample = (law == g711_pkg::LAW_A) ? a_expand(code) : mu_expand(code);
      return r;
   endfunction

   always @(posedge clock) begin
      conversion_type want;
      if (!reset && rsp_strobe) begin
         if (pending_conversions.size() == 0) begin
            $error("result with no request outstanding: code_out %h sample_out %h",
                   rsp_code_out, rsp_sample_out);
            error_count++;
         end else begin
            want = pending_conversions.pop_front();
            if (rsp_code_out !== want.code) begin
               $error("code_out: expected %h, actual %h", want.code, rsp_code_out);
               error_count++;
            end
            if (rsp_sample_out !== want.sample) begin
               $error("sample_out: expected %h, actual %h", want.sample, rsp_sample_out);
               error_count++;
            end
         end
      end
   end

   task automatic hold_start_low(int cycles);
      @(negedge clock);
      start <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic send_conversion(g711_pkg::op_type op, logic [15:0] sample,
                                  logic [7:0] code);
      @(negedge clock);
      start <= 1'b1;
      req_op <= op;
      req_sample_in <= sample;
      req_code_in <= code;
      do @(posedge clock); while (busy);
      pending_conversions.push_back(convert_request(op, sample, code, active_law));
   endtask

   task automatic write_law(g711_pkg::law_type law);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= LAW_SELECT_ADDR;
      pwdata <= {{(g711_pkg::CSR_DATA_W-1){1'b0}}, law};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      active_law = law;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic check_law_readback();
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= LAW_SELECT_ADDR;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== {{(g711_pkg::CSR_DATA_W-1){1'b0}}, active_law}) begin
         $error("law_select: expected %h, actual %h", active_law, prdata);
         error_count++;
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic drain_results();
      hold_start_low(1);
      while (pending_conversions.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic switch_law(g711_pkg::law_type law);
      drain_results();
      write_law(law);
      check_law_readback();
   endtask

   function automatic int random_gap();
      int r;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(3, 1);
      return $urandom_range(25, 5);
   endfunction

   function automatic logic [15:0] random_sample(g711_pkg::law_type law);
      int          r;
      logic [15:0] v;
      r = $urandom_range(99);
      if (r < 50) begin
         v = 16'($urandom);
      end else if (r < 75) begin
         v = 16'($urandom_range(300));
         if ($urandom_range(1)) v = -v;
      end else if (r < 90) begin
         v = 16'($urandom_range(8300, 3900));
         if ($urandom_range(1)) v = -v;
      end else begin
         case ($urandom_range(3))
            0: v = 16'h7FFF;
            1: v = 16'h8000;
            2: v = 16'h0000;
            default: v = 16'hFFFF;
         endcase
      end
      return (law == g711_pkg::LAW_A && r >= 50) ? swap_halves(v) : v;
   endfunction

   task automatic test_reset_value();
      check_law_readback();
   endtask

   task automatic test_mu_law_directed();
      logic [15:0] samples[$];
      logic [7:0]  codes[$];
      samples = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000,
                  16'd8158, 16'd8159, 16'd30, 16'd31, 16'hFFE1};
      codes = '{8'h00, 8'hFF, 8'h7F, 8'h80};
      switch_law(g711_pkg::LAW_MU);
      foreach (samples[i]) send_conversion(g711_pkg::OP_ENCODE, samples[i], 8'($urandom));
      foreach (codes[i]) send_conversion(g711_pkg::OP_DECODE, 16'($urandom), codes[i]);
   endtask

   task automatic test_a_law_directed();
      logic [15:0] samples[$];
      logic [7:0]  codes[$];
      samples = '{16'h0000, 16'h0100, 16'h1F00, 16'h2000, 16'hFF0F,
                  16'h0080, 16'hFF7F, 16'hFFFF};
      codes = '{8'h55, 8'hD5, 8'h00, 8'hFF};
      switch_law(g711_pkg::LAW_A);
      foreach (samples[i]) send_conversion(g711_pkg::OP_ENCODE, samples[i], 8'($urandom));
      foreach (codes[i]) send_conversion(g711_pkg::OP_DECODE, 16'($urandom), codes[i]);
   endtask

   task automatic test_random_traffic();
      g711_pkg::law_type phase_laws[$];
      bit                steady;
      int                gap;
      phase_laws = '{g711_pkg::LAW_A, g711_pkg::LAW_MU, g711_pkg::LAW_A,
                     g711_pkg::LAW_MU, g711_pkg::LAW_A};
      foreach (phase_laws[p]) begin
         switch_law(phase_laws[p]);
         steady = ($urandom_range(3) == 0);
         repeat (110) begin
            if ($urandom_range(1))
               send_conversion(g711_pkg::OP_DECODE, 16'($urandom), 8'($urandom));
            else
               send_conversion(g711_pkg::OP_ENCODE, random_sample(active_law),
                               8'($urandom));
            gap = steady ? 0 : random_gap();
            if (gap > 0) hold_start_low(gap);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_op = g711_pkg::OP_ENCODE;
      req_sample_in = '0;
      req_code_in = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      active_law = g711_pkg::LAW_MU;
      error_count = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_value();
      test_mu_law_directed();
      test_a_law_directed();
      test_random_traffic();
      drain_results();

      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
